### rtl/core/tq_pkg.sv
package tq_pkg;

  localparam int NUM_IDS     = 1024;
  localparam int MAX_TEAMS   = 16;
  localparam int QUEUE_DEPTH = 256;

  localparam int NUM_GROUPS = MAX_TEAMS + 1;
  localparam int ID_W       = $clog2(NUM_IDS);
  localparam int GRP_W      = $clog2(NUM_GROUPS);
  localparam int IDX_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int ELEM_W = 10;
  localparam int TEAM_W = 5;

  typedef enum logic [1:0] {
    OP_ASSIGN  = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_DEQUEUE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ACK   = 2'd3
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [ELEM_W-1:0] elem_id;
    logic [TEAM_W-1:0] team_id;
  } in_item_t;

  typedef struct packed {
    logic [ELEM_W-1:0] out_elem;
    status_e           status;
  } out_item_t;

  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    logic [GRP_W-1:0]  grp;
  } entry_t;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_NEW,
    SEL_LEFT,
    SEL_RIGHT
  } sel_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [IDX_W-1:0] pos;
    entry_t           ent;
  } cmd_t;

endpackage

### rtl/core/grouped_fifo_team_queue.sv
// Channel | Dir | Handshake               | Payload
// --------+-----+-------------------------+-----------------------------
// in      | in  | in_valid_i / in_ready_o | in_item_i  (op, elem_id, team_id)
// out     | out | out_valid_o/out_ready_i | out_item_o (out_elem, status)
//
// Each item first reads the team RAM, then updates the counters and moves
// the cell row (insert or shift toward the head).
// One item in flight at a time; a result waits in the output register and
// a stalled output holds the item in the update state (S_EXEC).
// After reset and after each clear the team RAM is swept to zero, one entry
// a cycle over all NUM_IDS = 1024 entries; no item is accepted meanwhile.
module grouped_fifo_team_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tq_pkg::in_item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tq_pkg::out_item_t out_item_o
);
  import tq_pkg::*;

  typedef enum logic [2:0] {
    S_SWEEP = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } fsm_e;

  fsm_e             state_q, state_d;
  logic [ID_W-1:0]  sweep_q, sweep_d;
  in_item_t         item_q;
  logic [CNT_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] cnt_q [NUM_GROUPS];
  logic [CNT_W-1:0] cnt_d [NUM_GROUPS];
  logic [CNT_W-1:0] end_q [NUM_GROUPS];
  logic [CNT_W-1:0] end_d [NUM_GROUPS];
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             accept, can_emit, emit;
  logic             id_ok, team_ok;
  logic [GRP_W-1:0] grp_rd, grp, hgrp;
  logic [IDX_W-1:0] pos;
  logic             ram_we;
  logic [ID_W-1:0]  ram_waddr;
  logic [GRP_W-1:0] ram_wdata;
  cmd_t             cmd;
  entry_t           head;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign can_emit   = !out_valid_q || out_ready_i;
  assign emit       = (state_q == S_EXEC) && can_emit;

  tq_team_ram u_team_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(ID_W'(in_item_i.elem_id)),
    .rdata_o(grp_rd)
  );

  tq_chain u_chain (
    .clk_i (clk_i),
    .cmd_i (cmd),
    .head_o(head)
  );

  assign id_ok   = (32'(item_q.elem_id) < 32'(NUM_IDS));
  assign team_ok = (item_q.team_id != '0) && (32'(item_q.team_id) <= 32'(MAX_TEAMS));
  assign grp     = (id_ok && (32'(grp_rd) <= 32'(MAX_TEAMS))) ? grp_rd : '0;
  assign hgrp    = head.grp;

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    total_d     = total_q;
    cnt_d       = cnt_q;
    end_d       = end_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = ID_W'(item_q.elem_id);
    ram_wdata   = GRP_W'(item_q.team_id);
    pos         = '0;
    cmd.kind    = CMD_HOLD;
    cmd.pos     = '0;
    cmd.ent     = '{elem: item_q.elem_id, grp: grp};

    unique case (state_q)
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = '0;
        sweep_d   = sweep_q + ID_W'(1);
        if (sweep_q == ID_W'(NUM_IDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_emit) begin
          state_d         = S_IDLE;
          out_valid_d     = 1'b1;
          out_d.out_elem  = '0;
          out_d.status    = ST_ACK;
          case (item_q.op)
            OP_ASSIGN: begin
              ram_we = id_ok && team_ok && (grp_rd == '0);
            end
            OP_ENQUEUE: begin
              if (total_q >= CNT_W'(QUEUE_DEPTH)) begin
                out_d.status = ST_FULL;
              end else begin
                out_d.status = ST_OK;
                if (cnt_q[grp] == '0) begin
                  pos = total_q[IDX_W-1:0];
                end else begin
                  pos = end_q[grp][IDX_W-1:0];
                  // groups at or behind the insert point move back one place
                  for (int h = 0; h < NUM_GROUPS; h++) begin
                    if (cnt_q[h] != '0 && end_q[h] >= CNT_W'(pos)) begin
                      end_d[h] = end_q[h] + CNT_W'(1);
                    end
                  end
                end
                if (cnt_q[grp] == '0) begin
                  end_d[grp] = total_q + CNT_W'(1);
                end
                cnt_d[grp] = cnt_q[grp] + CNT_W'(1);
                total_d    = total_q + CNT_W'(1);
                cmd.kind   = CMD_INSERT;
                cmd.pos    = pos;
              end
            end
            OP_DEQUEUE: begin
              if (total_q == '0) begin
                out_d.status = ST_EMPTY;
              end else begin
                out_d.status   = ST_OK;
                out_d.out_elem = head.elem;
                for (int h = 0; h < NUM_GROUPS; h++) begin
                  if (cnt_q[h] != '0) begin
                    end_d[h] = end_q[h] - CNT_W'(1);
                  end
                end
                cnt_d[hgrp] = cnt_q[hgrp] - CNT_W'(1);
                total_d     = total_q - CNT_W'(1);
                cmd.kind    = CMD_SHIFT;
              end
            end
            default: begin
              for (int h = 0; h < NUM_GROUPS; h++) begin
                cnt_d[h] = '0;
              end
              total_d = '0;
              sweep_d = '0;
              state_d = S_SWEEP;
            end
          endcase
        end
      end
      default: state_d = S_SWEEP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int h = 0; h < NUM_GROUPS; h++) begin
        cnt_q[h] <= '0;
      end
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    end_q <= end_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_accept_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> !in_ready_o)
    else $error("item accepted during RAM sweep");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_d.status == ST_FULL) |-> (total_q == CNT_W'(QUEUE_DEPTH)))
    else $error("full reported on a queue with room");

  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && item_q.op == OP_DEQUEUE && out_d.status == ST_OK)
      |=> (total_q == $past(total_q) - CNT_W'(1)))
    else $error("dequeue did not drop the count");

endmodule

### rtl/core/tq_cell.sv
module tq_cell (
  input  logic            clk_i,
  input  tq_pkg::sel_e    sel_i,
  input  tq_pkg::entry_t  new_i,
  input  tq_pkg::entry_t  left_i,
  input  tq_pkg::entry_t  right_i,
  output tq_pkg::entry_t  ent_o
);
  import tq_pkg::*;

  entry_t ent_q, ent_d;

  always_comb begin
    case (sel_i)
      SEL_NEW:   ent_d = new_i;
      SEL_LEFT:  ent_d = left_i;
      SEL_RIGHT: ent_d = right_i;
      default:   ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

### rtl/core/tq_chain.sv
module tq_chain (
  input  logic           clk_i,
  input  tq_pkg::cmd_t   cmd_i,
  output tq_pkg::entry_t head_o
);
  import tq_pkg::*;

  entry_t ent [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_w, right_w;
    sel_e   sel_w;

    if (i == 0) begin : g_first
      assign left_w = cmd_i.ent;
    end else begin : g_left
      assign left_w = ent[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_w = cmd_i.ent;
    end else begin : g_right
      assign right_w = ent[i+1];
    end

    // insert at pos: cells past it move one place toward the tail
    always_comb begin
      case (cmd_i.kind)
        CMD_SHIFT: sel_w = SEL_RIGHT;
        CMD_INSERT: begin
          if (cmd_i.pos == IDX_W'(i)) begin
            sel_w = SEL_NEW;
          end else if (cmd_i.pos < IDX_W'(i)) begin
            sel_w = SEL_LEFT;
          end else begin
            sel_w = SEL_HOLD;
          end
        end
        default: sel_w = SEL_HOLD;
      endcase
    end

    tq_cell u_cell (
      .clk_i  (clk_i),
      .sel_i  (sel_w),
      .new_i  (cmd_i.ent),
      .left_i (left_w),
      .right_i(right_w),
      .ent_o  (ent[i])
    );
  end

  assign head_o = ent[0];

endmodule

### rtl/core/tq_team_ram.sv
module tq_team_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [tq_pkg::ID_W-1:0]  waddr_i,
  input  logic [tq_pkg::GRP_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [tq_pkg::ID_W-1:0]  raddr_i,
  output logic [tq_pkg::GRP_W-1:0] rdata_o
);
  import tq_pkg::*;

  logic [GRP_W-1:0] mem [NUM_IDS];
  logic [GRP_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
